>>> src/visibility_freq_time_averager_core_macros.svh
// Assertion macros for the visibility averager core.
// Used by the back end and the top level; no other dependencies.
`ifndef VISIBILITY_FREQ_TIME_AVERAGER_CORE_MACROS_SVH
`define VISIBILITY_FREQ_TIME_AVERAGER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define VFTA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VFTA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VFTA_ASSERT(label, clk, rst, prop, msg)
`define VFTA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> src/vfta_pkg.sv
// Shared types, widths and state codes for the visibility averager core.
// No dependencies.
package vfta_pkg;
  localparam int MAX_CHANNELS_DEF = 1024;
  localparam int MAX_BUNCH_DEF = 64;
  localparam int MAX_INTEG_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CPR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUNCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONJ = 3'd5;

  localparam int DIV_STEPS = 48;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_ACC, BK_DIV, BK_OUT
  } bk_state_t;
endpackage

>>> src/vfta_front.sv
// Front end: accepts samples, tracks channel/record/group counters, checks skew.
// Depends on vfta_pkg.
module vfta_front
  import vfta_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_BUNCH = MAX_BUNCH_DEF,
  parameter int MAX_INTEG = MAX_INTEG_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CW = $clog2(MAX_CHANNELS),
  localparam int BW = $clog2(MAX_BUNCH + 1),
  localparam int IW = $clog2(MAX_INTEG + 1),
  localparam int QW = CW + 2 * SAMPLE_BITS + 59 + IW + 20 + BW + 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample_re,
  input  logic [SAMPLE_BITS-1:0] sample_im,
  input  logic [47:0]            data_time,
  input  logic [47:0]            flag_time,
  input  logic [10:0]            cfg_cpr,
  input  logic [6:0]             cfg_bunch,
  input  logic [10:0]            cfg_integ,
  input  logic [20:0]            cfg_total,
  input  logic [47:0]            cfg_skew,
  input  logic                   cfg_conj,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic [QW-1:0]          q_data
);
  logic [CW:0] cpr;
  logic [BW-1:0] bun;
  logic [IW-1:0] integ;
  logic [20:0] total;
  logic [CW:0] c;
  logic [CW:0] c_next;
  logic [BW-1:0] sub;
  logic [CW-1:0] k;
  logic [CW:0] nbase;
  logic [IW-1:0] rig;
  logic [20:0] rdone;
  logic [19:0] gdone;
  logic [58:0] tsum;
  logic [58:0] tsum_now;
  logic halted;
  logic take;
  logic skew_err;
  logic [47:0] diff;
  logic last_rec;
  logic in_bunch;
  logic first;
  logic emit;
  logic glast;
  logic [CW:0] bun_x;
  logic [CW:0] nch_end;

  always_comb begin
    cpr = (cfg_cpr == '0) ? (CW+1)'(1) :
          (32'(cfg_cpr) > MAX_CHANNELS) ? (CW+1)'(MAX_CHANNELS) : (CW+1)'(cfg_cpr);
    bun = (cfg_bunch == '0) ? BW'(1) :
          (32'(cfg_bunch) > MAX_BUNCH) ? BW'(MAX_BUNCH) : BW'(cfg_bunch);
    integ = (cfg_integ == '0) ? IW'(1) :
            (32'(cfg_integ) > MAX_INTEG) ? IW'(MAX_INTEG) : IW'(cfg_integ);
    total = (cfg_total == '0) ? 21'd1 : cfg_total;
    bun_x = (CW+1)'(bun);
    nch_end = nbase + bun_x;
    in_bunch = (nch_end <= cpr);
    diff = (data_time > flag_time) ? data_time - flag_time : flag_time - data_time;
    skew_err = (c == '0) && (diff > cfg_skew);
    tsum_now = (c == '0) ? tsum + 59'(data_time) : tsum;
    last_rec = (32'(rig) + 1 >= 32'(integ)) || (rdone + 21'd1 >= total);
    first = (rig == '0) && (sub == '0);
    emit = in_bunch && last_rec && (32'(sub) == 32'(bun) - 1);
    glast = emit && ((nch_end + bun_x) > cpr);
    in_ready = halted || !q_valid || q_ready;
    take = in_valid && in_ready && !halted;
    c_next = c + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c <= '0; sub <= '0; k <= '0; nbase <= '0; rig <= '0; rdone <= '0;
      gdone <= '0; tsum <= '0; halted <= 1'b0; q_valid <= 1'b0;
    end else begin
      if (take) q_valid <= skew_err || in_bunch;
      else if (q_ready) q_valid <= 1'b0;
      if (take) begin
        q_data <= {k, sample_re, sample_im, tsum_now, rig, gdone, bun,
                   skew_err, first, emit, glast,
                   glast && (rdone + 21'd1 >= total), cfg_conj};
        if (skew_err) begin
          halted <= 1'b1;
        end else if (c_next >= cpr) begin
          c <= '0; sub <= '0; k <= '0; nbase <= '0;
          rdone <= rdone + 21'd1;
          if (rdone + 21'd1 >= total) halted <= 1'b1;
          if (last_rec) begin
            rig <= '0; tsum <= '0; gdone <= gdone + 20'd1;
          end else begin
            rig <= rig + 1'b1; tsum <= tsum_now;
          end
        end else begin
          c <= c_next;
          tsum <= tsum_now;
          if (32'(sub) == 32'(bun) - 1) begin
            sub <= '0; k <= k + 1'b1; nbase <= nch_end;
          end else begin
            sub <= sub + 1'b1;
          end
        end
      end
    end
  end
endmodule

>>> src/vfta_back.sv
// Back end: accumulator memory read-modify-write, serial divide, result register.
// Depends on vfta_pkg and the macros header.
`include "visibility_freq_time_averager_core_macros.svh"
module vfta_back
  import vfta_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_BUNCH = MAX_BUNCH_DEF,
  parameter int MAX_INTEG = MAX_INTEG_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CW = $clog2(MAX_CHANNELS),
  localparam int BW = $clog2(MAX_BUNCH + 1),
  localparam int IW = $clog2(MAX_INTEG + 1),
  localparam int QW = CW + 2 * SAMPLE_BITS + 59 + IW + 20 + BW + 6,
  localparam int OW = 10 + 2 * SAMPLE_BITS + 48 + 20 + 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  output logic          o_valid,
  input  logic          o_ready,
  output logic [OW-1:0] o_data
);
  localparam int DW = 59;
  logic [QW-1:0] item, cur;
  logic [CW-1:0] k;
  logic signed [SAMPLE_BITS-1:0] sre, sim;
  logic [58:0] tsum;
  logic [IW-1:0] rig;
  logic [19:0] gidx;
  logic [BW-1:0] bun;
  logic err, first, emit, glast, rdone, conj;
  logic [31:0] mem_re [MAX_CHANNELS];
  logic [31:0] mem_im [MAX_CHANNELS];
  logic [31:0] rd_re, rd_im;
  logic signed [31:0] acc_re, acc_im;
  logic signed [33:0] sum_re, sum_im;
  logic signed [SAMPLE_BITS+1:0] im_eff;
  bk_state_t state, state_next;
  logic [6:0] step;
  logic [DW-1:0] den;
  logic [DW-1:0] dent;
  logic [31:0] qr, qi;
  logic [DW-1:0] qt;
  logic [31:0] rr, ri;
  logic [DW-1:0] rt;
  logic [32:0] trr, tri_;
  logic [DW:0] trt;
  logic [31:0] mag_re, mag_im;
  logic neg_re, neg_im;
  logic signed [32:0] fre, fim;
  logic signed [SAMPLE_BITS-1:0] ore, oim;
  localparam logic signed [32:0] SMAX = 33'sd1 <<< (SAMPLE_BITS - 1);

  assign cur = (state == BK_IDLE) ? q_data : item;
  assign {k, sre, sim, tsum, rig, gidx, bun, err, first, emit, glast, rdone, conj} = cur;
  assign q_ready = (state == BK_IDLE) && !o_valid;

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_valid && q_ready) begin
      item <= q_data;
      rd_re <= mem_re[k];
      rd_im <= mem_im[k];
    end
    if (state == BK_ACC) begin
      mem_re[k] <= acc_re;
      mem_im[k] <= acc_im;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    im_eff = conj ? -(SAMPLE_BITS+2)'(sim) : (SAMPLE_BITS+2)'(sim);
    sum_re = (first ? 34'sd0 : 34'(signed'(rd_re))) + 34'(sre);
    sum_im = (first ? 34'sd0 : 34'(signed'(rd_im))) + 34'(im_eff);
    acc_re = sat32(sum_re);
    acc_im = sat32(sum_im);
    trr = {rr[30:0], qr[31]} - {1'b0, den[31:0]};
    tri_ = {ri[30:0], qi[31]} - {1'b0, den[31:0]};
    trt = {rt, qt[DW-1]} - {1'b0, dent};
    fre = neg_re ? -33'(qr) : 33'(qr);
    fim = neg_im ? -33'(qi) : 33'(qi);
    ore = (fre >= SMAX) ? SAMPLE_BITS'(SMAX - 1) :
          (fre < -SMAX) ? SAMPLE_BITS'(-SMAX) : fre[SAMPLE_BITS-1:0];
    oim = (fim >= SMAX) ? SAMPLE_BITS'(SMAX - 1) :
          (fim < -SMAX) ? SAMPLE_BITS'(-SMAX) : fim[SAMPLE_BITS-1:0];
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid && q_ready) state_next = err ? BK_OUT : BK_READ;
      BK_READ: state_next = BK_ACC;
      BK_ACC:  state_next = emit ? BK_DIV : BK_IDLE;
      BK_DIV:  if (step == 7'(DIV_STEPS + 11 - 1)) state_next = BK_OUT;
      BK_OUT:  state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      if (state == BK_OUT) o_valid <= 1'b1;
      else if (o_ready) o_valid <= 1'b0;
      if (state == BK_ACC) begin
        step <= '0;
        den <= DW'(32'(bun) * 32'({1'b0, rig} + 1'b1));
        dent <= DW'({1'b0, rig} + 1'b1);
        neg_re <= acc_re[31]; neg_im <= acc_im[31];
        qr <= acc_re[31] ? -acc_re : acc_re;
        qi <= acc_im[31] ? -acc_im : acc_im;
        rr <= '0; ri <= '0;
        qt <= tsum;
        rt <= '0;
      end
      if (state == BK_DIV) begin
        step <= step + 1'b1;
        if (step < 7'd32) begin
          if (!trr[32]) begin rr <= trr[31:0]; qr <= {qr[30:0], 1'b1}; end
          else begin rr <= {rr[30:0], qr[31]}; qr <= {qr[30:0], 1'b0}; end
          if (!tri_[32]) begin ri <= tri_[31:0]; qi <= {qi[30:0], 1'b1}; end
          else begin ri <= {ri[30:0], qi[31]}; qi <= {qi[30:0], 1'b0}; end
        end
        if (!trt[DW]) begin rt <= trt[DW-1:0]; qt <= {qt[DW-2:0], 1'b1}; end
        else begin rt <= {rt[DW-2:0], qt[DW-1]}; qt <= {qt[DW-2:0], 1'b0}; end
      end
      if (state == BK_OUT) begin
        if (err) o_data <= {10'd0, {2*SAMPLE_BITS{1'b0}}, 48'd0, gidx, 1'b1, 1'b0, 1'b1};
        else o_data <= {10'(k), ore, oim, qt[47:0], gidx, 1'b0, glast, rdone};
      end
    end
  end

  `VFTA_ASSERT(a_no_take_busy, clk, rst, (q_valid && q_ready) |-> state == BK_IDLE,
    "item taken while back end busy")
  `VFTA_ASSERT(a_out_after_state, clk, rst, $rose(o_valid) |-> $past(state) == BK_OUT,
    "result without output step")
  `VFTA_ASSERT(a_no_over, clk, rst, (o_valid && !o_ready) |=> o_valid && $stable(o_data),
    "pending result lost")
endmodule

>>> src/visibility_freq_time_averager_core.sv
// Top level of the visibility averager: config registers, front end, back end.
// Depends on vfta_pkg, vfta_front, vfta_back and the macros header.
// channel | dir | width    | contents
// s_axis  | in  | 128      | sample_re, sample_im, data_time, flag_time
// m_axis  | out | 112 + 1  | out_channel, avg_re, avg_im, avg_time, group_index, flags
// cfg     | in  | 3 + 48   | register index, write data
// Each item without a skew error passes through the back end's read and accumulate states;
// an emitting item then goes through the serial 59-step divider and the result load.
// Reset clears counters and halt; accumulator memory is not cleared.
// Stalls on m_axis hold the back end; the front end keeps one item queued.
`include "visibility_freq_time_averager_core_macros.svh"
module visibility_freq_time_averager_core
  import vfta_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_BUNCH = MAX_BUNCH_DEF,
  parameter int MAX_INTEG = MAX_INTEG_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int DIW = 2 * SAMPLE_BITS + 96,
  localparam int DOW = ((10 + 2 * SAMPLE_BITS + 48 + 20 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DIW-1:0]       s_axis_tdata,  // sample_re, sample_im, data_time, flag_time
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DOW-1:0]       m_axis_tdata,  // out_channel, avg_re, avg_im, avg_time, group_index, status, run_done
  output logic                 m_axis_tlast,  // group_last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data
);
  localparam int CW = $clog2(MAX_CHANNELS);
  localparam int BW = $clog2(MAX_BUNCH + 1);
  localparam int IW = $clog2(MAX_INTEG + 1);
  localparam int QW = CW + 2 * SAMPLE_BITS + 59 + IW + 20 + BW + 6;
  localparam int OW = 10 + 2 * SAMPLE_BITS + 48 + 20 + 3;

  logic [10:0] cpr, integ;
  logic [6:0] bunch;
  logic [20:0] total;
  logic [47:0] skew;
  logic conj;
  logic q_valid, q_ready;
  logic [QW-1:0] q_data;
  logic [OW-1:0] o_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cpr <= 11'd1024; bunch <= 7'd1; integ <= 11'd1; total <= 21'd1;
      skew <= '0; conj <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CPR:   cpr <= cfg_data[10:0];
        REG_BUNCH: bunch <= cfg_data[6:0];
        REG_INTEG: integ <= cfg_data[10:0];
        REG_TOTAL: total <= cfg_data[20:0];
        REG_SKEW:  skew <= cfg_data;
        REG_CONJ:  conj <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vfta_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_BUNCH(MAX_BUNCH),
               .MAX_INTEG(MAX_INTEG), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sample_re(s_axis_tdata[SAMPLE_BITS-1:0]),
    .sample_im(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .data_time(s_axis_tdata[2*SAMPLE_BITS+47:2*SAMPLE_BITS]),
    .flag_time(s_axis_tdata[2*SAMPLE_BITS+95:2*SAMPLE_BITS+48]),
    .cfg_cpr(cpr), .cfg_bunch(bunch), .cfg_integ(integ), .cfg_total(total),
    .cfg_skew(skew), .cfg_conj(conj),
    .q_valid, .q_ready, .q_data
  );

  vfta_back #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_BUNCH(MAX_BUNCH),
              .MAX_INTEG(MAX_INTEG), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data
  );

  // o_data high to low: channel, re, im, time, group, status, last, done
  assign m_axis_tdata = DOW'({o_data[0], o_data[2], o_data[22:3], o_data[70:23],
                              o_data[OW-27:71], o_data[OW-11:OW-26],
                              o_data[OW-1:OW-10]});
  assign m_axis_tlast = o_data[1];

  `VFTA_ASSERT(a_cfg_idle, clk, rst, cfg_valid |-> !m_axis_tvalid,
    "config write while result pending")
endmodule
